// File: rtl/spq_pkg.sv
// spq_pkg: shared types and constants of the stable priority queue.
// Item structs, slot layout and cell control; no dependencies.
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PRIO_W      = 8;
	localparam int PAY_W       = 16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [PRIO_W-1:0] entry_priority;
		logic [PAY_W-1:0]  entry_payload;
	} in_item_t;

	typedef struct packed {
		logic              pop_valid;
		logic [PRIO_W-1:0] pop_priority;
		logic [PAY_W-1:0]  pop_payload;
		logic              push_refused;
		logic [CNT_W-1:0]  fill_level;
	} out_item_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} slot_t;

	typedef struct packed {
		logic  push_en;
		logic  pop_en;
		slot_t new_slot;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/spq_cell.sv
// spq_cell: one slot of the sorted insertion chain.
// Shifts toward the tail on a push at or ahead of it, toward the head on a pop; uses spq_pkg.
`default_nettype none
module spq_cell (
	input  wire logic               clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire logic               occupied,
	input  wire logic               prev_take,
	input  wire spq_pkg::slot_t     prev_slot,
	input  wire spq_pkg::slot_t     next_slot,
	output      logic               take,
	output      spq_pkg::slot_t     slot
);

	spq_pkg::slot_t slot_q;

	// new entry belongs at or ahead of this cell
	assign take = !occupied || (slot_q.prio < ctrl.new_slot.prio);
	assign slot = slot_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop_en) begin
			slot_q <= next_slot;
		end else if (ctrl.push_en && take) begin
			if (prev_take) begin
				slot_q <= prev_slot;
			end else begin
				slot_q <= ctrl.new_slot;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/stable_priority_queue_core.sv
// stable_priority_queue_core: bounded priority queue as a chain of compare cells.
// Result strobe: registered, raised in the cycle after an item is accepted.
// Throughput: one push or pop per cycle; busy stays low.
// Reset: entry count and strobe clear asynchronously; slot contents are not reset.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Uses spq_pkg and spq_cell.
`default_nettype none
module stable_priority_queue_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire spq_pkg::in_item_t  cmd,
	output      logic               done,
	output      spq_pkg::out_item_t result
);

	localparam int D = spq_pkg::QUEUE_DEPTH;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      done_q;
	spq_pkg::out_item_t        result_q;

	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::slot_t      slots [D];
	logic [D-1:0]        takes;
	logic [D-1:0]        occ;

	logic accept, is_push, is_pop, full, empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == spq_pkg::CNT_W'(D));
	assign empty  = (count_q == '0);
	assign is_push = accept && (cmd.operation == spq_pkg::OP_PUSH);
	assign is_pop  = accept && (cmd.operation == spq_pkg::OP_POP);

	assign ctrl.push_en          = is_push && !full;
	assign ctrl.pop_en           = is_pop && !empty;
	assign ctrl.new_slot.prio    = cmd.entry_priority;
	assign ctrl.new_slot.payload = cmd.entry_payload;

	genvar i;
	generate
		for (i = 0; i < D; i++) begin : g_cell
			assign occ[i] = (spq_pkg::CNT_W'(i) < count_q);
			spq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occupied  (occ[i]),
				.prev_take ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1]),
				.prev_slot (slots[(i == 0) ? 0 : i-1]),
				.next_slot (slots[(i == D-1) ? D-1 : i+1]),
				.take      (takes[i]),
				.slot      (slots[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.push_en) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.pop_valid    <= ctrl.pop_en;
			result_q.pop_priority <= ctrl.pop_en ? slots[0].prio : '0;
			result_q.pop_payload  <= ctrl.pop_en ? slots[0].payload : '0;
			result_q.push_refused <= is_push && full;
			if (ctrl.push_en) begin
				result_q.fill_level <= count_q + 1'b1;
			end else if (ctrl.pop_en) begin
				result_q.fill_level <= count_q - 1'b1;
			end else begin
				result_q.fill_level <= count_q;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(D))
		else $error("entry count above depth");

	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result strobe");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.push_refused) |-> (result.fill_level == spq_pkg::CNT_W'(D)))
		else $error("push refused below full");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop_en |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not drop the count");

endmodule
`default_nettype wire

// File: tb/stable_priority_queue_core_tb.sv
// Testbench for stable_priority_queue_core: directed and random push/pop items with an
// in-bench priority queue predictor, checked field by field on every done strobe.
// Depends on spq_pkg and the stable_priority_queue_core RTL.
`timescale 1ns / 100ps
module stable_priority_queue_core_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 750;

	typedef struct {
		spq_pkg::in_item_t cmd;
		int unsigned       gap;
		bit                drain;
	} queued_op_t;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	spq_pkg::in_item_t  cmd    = '0;
	logic               busy;
	logic               done;
	spq_pkg::out_item_t result;

	queued_op_t         op_queue[$];
	spq_pkg::out_item_t pending_results[$];
	queued_op_t staged_op;
	bit         staged = 1'b0;
	int unsigned gap_left = 0;
	int         pred_cnt = 0;
	int         chk_cnt = 0;
	int         err_cnt = 0;
	int         cycle_cnt = 0;
	int         total_items = 0;

	// predictor state
	logic [spq_pkg::PRIO_W-1:0] held_prio [spq_pkg::QUEUE_DEPTH];
	logic [spq_pkg::PAY_W-1:0]  held_pay  [spq_pkg::QUEUE_DEPTH];
	int held = 0;
	int n_push = 0, n_pop = 0, n_refused = 0, n_empty_pop = 0, n_tie = 0, peak_fill = 0;

	spq_pkg::out_item_t want;

	stable_priority_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	function automatic spq_pkg::out_item_t apply_queue_op(spq_pkg::in_item_t c);
		spq_pkg::out_item_t r;
		int pos;
		r = '0;
		if (c.operation == spq_pkg::OP_PUSH) begin
			n_push++;
			if (held >= spq_pkg::QUEUE_DEPTH) begin
				r.push_refused = 1'b1;
				n_refused++;
			end else begin
				pos = held;
				// new entry goes behind every entry of equal or higher priority
				while (pos > 0 && held_prio[pos-1] < c.entry_priority) begin
					held_prio[pos] = held_prio[pos-1];
					held_pay[pos]  = held_pay[pos-1];
					pos--;
				end
				if (pos > 0 && held_prio[pos-1] == c.entry_priority)
					n_tie++;
				held_prio[pos] = c.entry_priority;
				held_pay[pos]  = c.entry_payload;
				held++;
				if (held > peak_fill)
					peak_fill = held;
			end
		end else begin
			n_pop++;
			if (held == 0) begin
				n_empty_pop++;
			end else begin
				r.pop_valid    = 1'b1;
				r.pop_priority = held_prio[0];
				r.pop_payload  = held_pay[0];
				for (int i = 0; i + 1 < held; i++) begin
					held_prio[i] = held_prio[i+1];
					held_pay[i]  = held_pay[i+1];
				end
				held--;
			end
		end
		r.fill_level = held[spq_pkg::CNT_W-1:0];
		return r;
	endfunction

	task automatic add_op(logic op, logic [spq_pkg::PRIO_W-1:0] prio,
			logic [spq_pkg::PAY_W-1:0] pay, int unsigned gap, bit drain);
		queued_op_t q;
		q.cmd.operation      = op;
		q.cmd.entry_priority = prio;
		q.cmd.entry_payload  = pay;
		q.gap   = gap;
		q.drain = drain;
		op_queue.push_back(q);
		total_items++;
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
		$display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
			$realtime, chk_cnt, what, got, exp);
		err_cnt++;
	endtask

	// driver
	always @(posedge clk) begin : drive
		logic acc;
		logic nxt_start;
		if (arst_n) begin
			acc = start && !busy;
			nxt_start = start && !acc;
			if (acc) begin
				pending_results.push_back(apply_queue_op(cmd));
				pred_cnt <= pred_cnt + 1;
			end
			if (!nxt_start) begin
				if (!staged && op_queue.size() > 0) begin
					staged_op = op_queue.pop_front();
					staged    = 1'b1;
					gap_left  = staged_op.gap;
				end
				if (staged) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (!staged_op.drain || (!acc && chk_cnt == pred_cnt)) begin
						nxt_start = 1'b1;
						cmd <= staged_op.cmd;
						staged = 1'b0;
					end
				end
			end
			start <= nxt_start;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (chk_cnt >= pred_cnt) begin
				report_mismatch("result with nothing pending", result, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.pop_valid !== want.pop_valid)
					report_mismatch("pop_valid", result.pop_valid, want.pop_valid);
				if (result.pop_priority !== want.pop_priority)
					report_mismatch("pop_priority", result.pop_priority, want.pop_priority);
				if (result.pop_payload !== want.pop_payload)
					report_mismatch("pop_payload", result.pop_payload, want.pop_payload);
				if (result.push_refused !== want.push_refused)
					report_mismatch("push_refused", result.push_refused, want.push_refused);
				if (result.fill_level !== want.fill_level)
					report_mismatch("fill_level", result.fill_level, want.fill_level);
				chk_cnt <= chk_cnt + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results checked",
				cycle_cnt, chk_cnt, pred_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int n_rand;
		int kind;
		int len;
		int gap_mode;
		int prio_mode;
		int push_pct;
		bit drain_first;
		logic op;
		logic [spq_pkg::PRIO_W-1:0] prio;
		logic [spq_pkg::PAY_W-1:0]  pay;
		int unsigned gap;

		// directed: empty pop, extremes, ties at both ends, drain back to empty
		add_op(spq_pkg::OP_POP,  8'hFF, 16'hFFFF, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h00, 16'h0000, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'hFF, 16'hFFFF, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h80, 16'h1111, 3, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h80, 16'h2222, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h80, 16'h3333, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h00, 16'hAAAA, 1, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'hFF, 16'h5555, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h7F, 16'h8001, 0, 1'b0);
		for (int i = 0; i < 8; i++)
			add_op(spq_pkg::OP_POP, 8'h00, 16'h0000, (i == 4) ? 2 : 0, 1'b0);
		add_op(spq_pkg::OP_POP, 8'h55, 16'hAAAA, 0, 1'b0);
		add_op(spq_pkg::OP_PUSH, 8'h01, 16'hFFFE, 0, 1'b1);
		add_op(spq_pkg::OP_POP, 8'hAA, 16'h5555, 0, 1'b0);

		// random phases: filling, emptying and mixed, with varied tie density and gaps
		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			kind        = $urandom_range(0, 3);
			len         = (kind < 2) ? $urandom_range(30, 60) : $urandom_range(10, 50);
			gap_mode    = $urandom_range(0, 2);
			prio_mode   = $urandom_range(0, 2);
			drain_first = (n_rand == 0) || ($urandom_range(0, 3) == 0);
			case (kind)
				0: push_pct = 85;
				1: push_pct = 15;
				2: push_pct = 50;
				default: push_pct = 60;
			endcase
			for (int i = 0; i < len; i++) begin
				op = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
				case (prio_mode)
					0: prio = spq_pkg::PRIO_W'($urandom_range(0, 3));
					1: prio = spq_pkg::PRIO_W'($urandom_range(252, 255));
					default: prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
				endcase
				case (gap_mode)
					0: gap = 0;
					1: gap = $urandom_range(0, 18);
					default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
				endcase
				pay = spq_pkg::PAY_W'($urandom_range(0, 65535));
				add_op(op, prio, pay, gap, drain_first && i == 0);
				n_rand++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pred_cnt != total_items)
			@(posedge clk);
		while (chk_cnt != pred_cnt)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d items: %0d pushes (%0d refused when full, %0d behind equal priority)",
			total_items, n_push, n_refused, n_tie);
		$display("%0d pops (%0d on empty), peak fill %0d of %0d, %0d checked, %0d mismatches",
			n_pop, n_empty_pop, peak_fill, spq_pkg::QUEUE_DEPTH, chk_cnt, err_cnt);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_core.sv
tb/stable_priority_queue_core_tb.sv
